>>> rtl/core/tmp_pkg.sv
package tmp_pkg;

  localparam int unsigned CFG_W   = 28;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DIV_W   = 64;

  localparam logic [IDX_W-1:0] REG_DISTANCE = 2'd0;
  localparam logic [IDX_W-1:0] REG_VELOCITY = 2'd1;
  localparam logic [IDX_W-1:0] REG_ACCEL    = 2'd2;

  localparam logic [CFG_W-1:0] RST_DISTANCE = 28'd184320;
  localparam logic [CFG_W-1:0] RST_VELOCITY = 28'd384000;
  localparam logic [CFG_W-1:0] RST_ACCEL    = 28'd2560000;

  typedef enum logic [1:0] {
    SEG_ACCEL,
    SEG_CRUISE,
    SEG_DECEL,
    SEG_DONE
  } tmp_seg_t;

  typedef enum logic [3:0] {
    DS_IDLE,
    DS_MUL_DA,
    DS_MUL_VV,
    DS_CMP,
    DS_SQRT,
    DS_DIV_AET,
    DS_WAIT_AET,
    DS_DIV_AD,
    DS_WAIT_AD,
    DS_DIV_CET,
    DS_WAIT_CET
  } tmp_dstate_t;

  typedef struct packed {
    logic [CFG_W-1:0]  d;
    logic [CFG_W-1:0]  a;
    logic [CFG_W-1:0]  pk;
    logic [CFG_W-1:0]  ad;
    logic [TIME_W-1:0] aet;
    logic [TIME_W-1:0] cet;
    logic [TIME_W-1:0] det;
    logic              tri_mode;
  } tmp_derived_t;

  function automatic logic [TIME_W-1:0] sat32(input logic [63:0] x);
    logic [TIME_W-1:0] res;
    res = (x > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : x[TIME_W-1:0];
    return res;
  endfunction

endpackage

>>> rtl/core/tmp_div.sv
module tmp_div import tmp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W:0]   rem_r;
  logic [DIV_W:0]   rem_nxt;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] quo_nxt;
  logic [DIV_W-1:0] dvs_r;
  logic [DIV_W:0]   shifted;

  always_comb begin
    shifted = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
    if (shifted >= {1'b0, dvs_r}) begin
      rem_nxt = shifted - {1'b0, dvs_r};
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted;
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/core/tmp_derive.sv
module tmp_derive import tmp_pkg::*; #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output tmp_derived_t     drv,
  output logic             busy
);

  tmp_dstate_t st_r, st_nxt;

  logic [CFG_W-1:0]  dist_r, vel_r, acc_r;
  logic [CFG_W-1:0]  v_eff, a_eff;
  logic              cfg_hit;

  logic [55:0]       da_r, da_nxt, vv_r, vv_nxt;
  logic [55:0]       mul_p;
  logic [63:0]       sx_r, sx_nxt, sr_r, sr_nxt, sb_r, sb_nxt, sr_step;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [CFG_W-1:0]  pk_r, pk_nxt, ad_r, ad_nxt;
  logic [TIME_W-1:0] aet_r, aet_nxt, cet_r, cet_nxt, det_r, det_nxt, q_sat;
  logic              tri_r, tri_nxt;

  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_dend, div_dsor, div_quo;

  assign v_eff   = (vel_r == '0) ? CFG_W'(1) : vel_r;
  assign a_eff   = (acc_r == '0) ? CFG_W'(1) : acc_r;
  assign cfg_hit = cfg_we && (cfg_index == REG_DISTANCE || cfg_index == REG_VELOCITY ||
                              cfg_index == REG_ACCEL);

  tmp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dend),
    .divisor  (div_dsor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      DS_IDLE:     st_nxt = DS_IDLE;
      DS_MUL_DA:   st_nxt = DS_MUL_VV;
      DS_MUL_VV:   st_nxt = DS_CMP;
      DS_CMP:      st_nxt = (da_r <= vv_r) ? DS_SQRT : DS_DIV_AET;
      DS_SQRT:     if (cnt_r == 5'd31) st_nxt = DS_DIV_AET;
      DS_DIV_AET:  st_nxt = DS_WAIT_AET;
      DS_WAIT_AET: if (div_done) st_nxt = tri_r ? DS_IDLE : DS_DIV_AD;
      DS_DIV_AD:   st_nxt = DS_WAIT_AD;
      DS_WAIT_AD:  if (div_done) st_nxt = DS_DIV_CET;
      DS_DIV_CET:  st_nxt = DS_WAIT_CET;
      DS_WAIT_CET: if (div_done) st_nxt = DS_IDLE;
      default:     st_nxt = DS_IDLE;
    endcase
    if (cfg_hit) st_nxt = DS_MUL_DA;
  end

  always_comb begin
    da_nxt    = da_r;
    vv_nxt    = vv_r;
    sx_nxt    = sx_r;
    sr_nxt    = sr_r;
    sb_nxt    = sb_r;
    cnt_nxt   = cnt_r;
    pk_nxt    = pk_r;
    ad_nxt    = ad_r;
    aet_nxt   = aet_r;
    cet_nxt   = cet_r;
    det_nxt   = det_r;
    tri_nxt   = tri_r;
    div_start = 1'b0;
    div_dend  = '0;
    div_dsor  = 64'd1;
    q_sat     = sat32(div_quo);
    mul_p     = (st_r == DS_MUL_DA) ? (56'(dist_r) * 56'(a_eff)) : (56'(v_eff) * 56'(v_eff));
    if (sx_r >= sr_r + sb_r) begin
      sr_step = (sr_r >> 1) + sb_r;
    end else begin
      sr_step = sr_r >> 1;
    end
    case (st_r)
      DS_MUL_DA: da_nxt = mul_p;
      DS_MUL_VV: vv_nxt = mul_p;
      DS_CMP: begin
        tri_nxt = (da_r <= vv_r);
        sx_nxt  = 64'(da_r);
        sr_nxt  = '0;
        sb_nxt  = 64'd1 << 62;
        cnt_nxt = '0;
        pk_nxt  = v_eff;
      end
      DS_SQRT: begin
        if (sx_r >= sr_r + sb_r) sx_nxt = sx_r - (sr_r + sb_r);
        sr_nxt  = sr_step;
        sb_nxt  = sb_r >> 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd31) pk_nxt = sr_step[CFG_W-1:0];
      end
      DS_DIV_AET: begin
        div_start = 1'b1;
        div_dend  = 64'(pk_r) << TIME_BITS;
        div_dsor  = 64'(a_eff);
      end
      DS_WAIT_AET: begin
        if (div_done) begin
          aet_nxt = q_sat;
          if (tri_r) begin
            cet_nxt = q_sat;
            det_nxt = sat32({31'd0, q_sat, 1'b0});
            ad_nxt  = dist_r >> 1;
          end
        end
      end
      DS_DIV_AD: begin
        div_start = 1'b1;
        div_dend  = 64'(vv_r);
        div_dsor  = {35'd0, a_eff, 1'b0};
      end
      DS_WAIT_AD: begin
        if (div_done) ad_nxt = div_quo[CFG_W-1:0];
      end
      DS_DIV_CET: begin
        div_start = 1'b1;
        div_dend  = 64'(dist_r) << TIME_BITS;
        div_dsor  = 64'(v_eff);
      end
      DS_WAIT_CET: begin
        if (div_done) begin
          cet_nxt = q_sat;
          det_nxt = sat32(64'(q_sat) + 64'(aet_r));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= DS_MUL_DA;
      dist_r <= RST_DISTANCE;
      vel_r  <= RST_VELOCITY;
      acc_r  <= RST_ACCEL;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_DISTANCE: dist_r <= cfg_data;
          REG_VELOCITY: vel_r  <= cfg_data;
          REG_ACCEL:    acc_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    da_r  <= da_nxt;
    vv_r  <= vv_nxt;
    sx_r  <= sx_nxt;
    sr_r  <= sr_nxt;
    sb_r  <= sb_nxt;
    cnt_r <= cnt_nxt;
    pk_r  <= pk_nxt;
    ad_r  <= ad_nxt;
    aet_r <= aet_nxt;
    cet_r <= cet_nxt;
    det_r <= det_nxt;
    tri_r <= tri_nxt;
  end

  assign busy         = (st_r != DS_IDLE);
  assign drv.d        = dist_r;
  assign drv.a        = a_eff;
  assign drv.pk       = pk_r;
  assign drv.ad       = ad_r;
  assign drv.aet      = aet_r;
  assign drv.cet      = cet_r;
  assign drv.det      = det_r;
  assign drv.tri_mode = tri_r;

endmodule

>>> rtl/core/tmp_pipe.sv
module tmp_pipe import tmp_pkg::*; #(
  parameter int unsigned TICK_US   = 1000,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tmp_derived_t      drv,
  input  logic              hold,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TICK_W-1:0] in_elapsed_ticks,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CFG_W-1:0]  out_ref_position,
  output logic [CFG_W-1:0]  out_ref_velocity,
  output logic [1:0]        out_segment
);

  localparam logic [63:0] SCALED  = 64'(TICK_US) << TIME_BITS;
  localparam logic [63:0] USEC    = 64'd1000000;
  localparam logic [32:0] T_WHOLE = 33'(SCALED / USEC);
  localparam logic [19:0] T_FRAC  = 20'(SCALED % USEC);
  localparam logic [19:0] T_RECIP = 20'((64'(T_FRAC) << 20) / USEC);
  localparam logic [35:0] USEC36  = 36'd1000000;

  logic        adv;
  logic [7:0]  vld_r;
  logic        out_valid_r;

  logic [15:0] s1_tk_r;
  logic [48:0] s2_pq_r, s3_pq_r;
  logic [35:0] s2_prq_r, s2_pr_r, s3_pr_r, s3_m_r;
  logic [15:0] s3_qe_r;
  logic [31:0] s4_t_r;
  tmp_seg_t    s5_seg_r, s6_seg_r, s7_seg_r, s8_seg_r;
  logic [31:0] s5_x_r, s6_x_r, s7_x_r;
  logic [59:0] s6_m1_r;
  logic [27:0] s7_vel_r, s8_vel_r, s7_p1_r, s8_p1_r;
  logic [60:0] s8_m2_r;
  logic [27:0] pos_r, vel_r;
  tmp_seg_t    seg_r;

  logic [15:0] qe;
  logic [35:0] rem;
  logic [16:0] q;
  logic [31:0] t;
  tmp_seg_t    seg;
  logic [31:0] x;
  logic [27:0] mf1;
  logic [63:0] hi, p1w;
  logic [27:0] vel;
  logic [28:0] mf2;
  logic [63:0] half, posw, start;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !hold;

  always_comb begin
    qe  = s2_prq_r[35:20];
    rem = s3_pr_r - s3_m_r;
    q   = 17'(s3_qe_r) + 17'(rem >= USEC36);
    t   = sat32(64'(s3_pq_r) + 64'(q));
    if (s4_t_r <= drv.aet) begin
      seg = SEG_ACCEL;
      x   = s4_t_r;
    end else if (s4_t_r <= drv.cet) begin
      seg = SEG_CRUISE;
      x   = s4_t_r - drv.aet;
    end else if (s4_t_r <= drv.det) begin
      seg = SEG_DECEL;
      x   = s4_t_r - drv.cet;
    end else begin
      seg = SEG_DONE;
      x   = '0;
    end
    mf1 = (s5_seg_r == SEG_CRUISE) ? drv.pk : drv.a;
    hi  = 64'(s6_m1_r) >> TIME_BITS;
    p1w = 64'(drv.ad) + hi;
    case (s6_seg_r)
      SEG_ACCEL:  vel = (hi > 64'(drv.pk)) ? drv.pk : hi[27:0];
      SEG_CRUISE: vel = drv.pk;
      SEG_DECEL:  vel = (hi >= 64'(drv.pk)) ? 28'd0 : drv.pk - hi[27:0];
      default:    vel = '0;
    endcase
    mf2   = (s7_seg_r == SEG_ACCEL) ? {1'b0, s7_vel_r} : {1'b0, drv.pk} + {1'b0, s7_vel_r};
    half  = 64'(s8_m2_r) >> (TIME_BITS + 1);
    start = drv.tri_mode ? 64'(drv.ad) : ((drv.d >= drv.ad) ? 64'(drv.d - drv.ad) : 64'd0);
    case (s8_seg_r)
      SEG_ACCEL:  posw = half;
      SEG_CRUISE: posw = 64'(s8_p1_r);
      SEG_DECEL:  posw = start + half;
      default:    posw = 64'(drv.d);
    endcase
    if (posw > 64'(drv.d)) posw = 64'(drv.d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[6:0], in_valid && !hold};
      out_valid_r <= vld_r[7];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tk_r  <= in_elapsed_ticks;
      s2_pq_r  <= 49'(s1_tk_r) * 49'(T_WHOLE);
      s2_prq_r <= 36'(s1_tk_r) * 36'(T_RECIP);
      s2_pr_r  <= 36'(s1_tk_r) * 36'(T_FRAC);
      s3_pq_r  <= s2_pq_r;
      s3_pr_r  <= s2_pr_r;
      s3_qe_r  <= qe;
      s3_m_r   <= 36'(qe) * USEC36;
      s4_t_r   <= t;
      s5_seg_r <= seg;
      s5_x_r   <= x;
      s6_seg_r <= s5_seg_r;
      s6_x_r   <= s5_x_r;
      s6_m1_r  <= 60'(mf1) * 60'(s5_x_r);
      s7_seg_r <= s6_seg_r;
      s7_x_r   <= s6_x_r;
      s7_vel_r <= vel;
      s7_p1_r  <= (p1w > 64'(drv.d)) ? drv.d : p1w[27:0];
      s8_seg_r <= s7_seg_r;
      s8_vel_r <= s7_vel_r;
      s8_p1_r  <= s7_p1_r;
      s8_m2_r  <= 61'(mf2) * 61'(s7_x_r);
      pos_r    <= posw[27:0];
      vel_r    <= s8_vel_r;
      seg_r    <= s8_seg_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ref_position = pos_r;
  assign out_ref_velocity = vel_r;
  assign out_segment      = seg_r;

endmodule

>>> rtl/core/trapezoidal_motion_profile_unit.sv
// Channel   Ports                                  Beat
// in        in_valid/in_ready, in_elapsed_ticks    one tick count
// out       out_valid/out_ready, out_ref_*         position, velocity, segment
// cfg       cfg_we, cfg_index, cfg_data            one register write
//
// A beat enters every cycle while in_ready is high and passes stage registers
// s1 to s8 before it leaves. After reset and each distance, velocity or
// acceleration write, a multiplier, a square-root sequencer (if triangular) and
// a one-bit-per-cycle divider rebuild segment times while in_ready is low.
// A stalled output freezes the whole pipeline, so no beat is lost or repeated.
module trapezoidal_motion_profile_unit import tmp_pkg::*; #(
  parameter int unsigned TICK_US   = 1000,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TICK_W-1:0] in_elapsed_ticks,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CFG_W-1:0]  out_ref_position,
  output logic [CFG_W-1:0]  out_ref_velocity,
  output logic [1:0]        out_segment
);

  tmp_derived_t drv;
  logic         drv_busy;

  tmp_derive #(
    .TIME_BITS (TIME_BITS)
  ) u_derive (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .drv       (drv),
    .busy      (drv_busy)
  );

  tmp_pipe #(
    .TICK_US   (TICK_US),
    .TIME_BITS (TIME_BITS)
  ) u_pipe (
    .clk              (clk),
    .rst_n            (rst_n),
    .drv              (drv),
    .hold             (drv_busy),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_elapsed_ticks (in_elapsed_ticks),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ref_position (out_ref_position),
    .out_ref_velocity (out_ref_velocity),
    .out_segment      (out_segment)
  );

`ifndef ASSERT_OFF
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    drv_busy |-> !in_ready)
    else $error("input taken while segment times are rebuilt");

  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_segment == SEG_DONE) |-> (out_ref_velocity == '0))
    else $error("nonzero velocity after the move ended");

  a_pos_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ref_position <= drv.d))
    else $error("reference position beyond the target distance");
`endif

endmodule
